### sv/websocket_frame_deframer_assert.svh
// assertion macros shared by the parser and queue modules
// depends on nothing; included by the files that carry assertions
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// condition must hold on every clock edge outside reset
`define WSFD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// antecedent in a cycle implies consequent in that same cycle
`define WSFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define WSFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/wsfd_pkg.sv
// shared types and constants of the websocket frame deframer
// depends on nothing
`timescale 1ns / 1ps

package wsfd_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	localparam logic [6:0]  LEN_CODE_16     = 7'd126;
	localparam logic [6:0]  LEN_CODE_64     = 7'd127;
	localparam logic [3:0]  HDR_END_16      = 4'd4;
	localparam logic [3:0]  HDR_END_64      = 4'd10;
	localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;
	localparam int          QUEUE_DEPTH_DEF = 4;

	// one classified transaction, carried from parser to output stage
	typedef struct packed {
		kind_t       kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [62:0] length;
		logic [7:0]  data;
		logic [7:0]  key_byte;
		logic        last;
	} cmd_t;

endpackage

### sv/websocket_frame_deframer.sv
// top level of the websocket frame deframer: parser, queue, output stage
// depends on wsfd_pkg, wsfd_parse, wsfd_queue, wsfd_emit
//
// channel   direction  handshake          payload
// input     in         push / full        rx_byte
// result    out        empty / pop        kind fin reserved_bits opcode masked
//                                         decoded_length payload_byte last
// config    in         cfg_we             cfg_wdata (max_frame_bytes)
//
// one byte per cycle sustained while full is low; a result goes from the queue
// memory through the output register before it reaches the outputs
// the parser updates its state in the cycle the byte is taken
// a QUEUE_DEPTH entry queue plus the output register absorb result stalls
// full rises only when the queue is full; no clearing pass after reset
`timescale 1ns / 1ps

module websocket_frame_deframer
	import wsfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic        fin,
	output logic [2:0]  reserved_bits,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [62:0] decoded_length,
	output logic [7:0]  payload_byte,
	output logic        last,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic take;
	logic wr_en;
	cmd_t wr_cmd;
	logic rd_en;
	cmd_t rd_cmd;
	logic q_nonempty;

	// input transaction accepted
	assign take = push && !full;

	wsfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.wr_en     (wr_en),
		.wr_cmd    (wr_cmd)
	);

	wsfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_cmd   (wr_cmd),
		.rd_en    (rd_en),
		.rd_cmd   (rd_cmd),
		.full     (full),
		.nonempty (q_nonempty)
	);

	wsfd_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_nonempty     (q_nonempty),
		.q_cmd          (rd_cmd),
		.q_rd_en        (rd_en),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.fin            (fin),
		.reserved_bits  (reserved_bits),
		.opcode         (opcode),
		.masked         (masked),
		.decoded_length (decoded_length),
		.payload_byte   (payload_byte),
		.last           (last)
	);

endmodule

### sv/wsfd_parse.sv
// front end: frame header parser and payload byte classifier
// depends on wsfd_pkg and websocket_frame_deframer_assert.svh
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"

module wsfd_parse
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        wr_en,
	output cmd_t        wr_cmd
);

	phase_t      phase_q, phase_d;
	logic [3:0]  hcnt_q, hcnt_d;
	logic [7:0]  first_q, first_d;
	logic [6:0]  code_q, code_d;
	logic [63:0] acc_q, acc_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  kidx_q, kidx_d;
	logic        disc_q, disc_d;
	logic        masked_q, masked_d;
	logic [31:0] max_q;

	logic        fin_now;
	logic [63:0] fin_len;
	logic [3:0]  fin_hdr;
	logic [64:0] fin_sum;
	logic        too_big;
	logic [3:0]  hsize;
	logic [3:0]  hcnt_inc;
	logic [63:0] rem_dec;
	logic [7:0]  kbyte;

	// header completion detect and size check
	always_comb begin
		hcnt_inc = hcnt_q + 4'd1;
		rem_dec  = rem_q - 64'd1;
		hsize    = 4'd2;
		if (code_q == LEN_CODE_16)
			hsize = hsize + 4'd2;
		if (code_q == LEN_CODE_64)
			hsize = hsize + 4'd8;
		if (masked_q)
			hsize = hsize + 4'd4;
		fin_now = 1'b0;
		fin_len = acc_q;
		case (phase_q)
			PH_SECOND: begin
				fin_len = {57'd0, rx_byte[6:0]};
				fin_now = (rx_byte[6:0] != LEN_CODE_16) && (rx_byte[6:0] != LEN_CODE_64)
					&& !rx_byte[7];
			end
			PH_EXTLEN: begin
				fin_len = {acc_q[55:0], rx_byte};
				fin_now = !masked_q &&
					(hcnt_inc == ((code_q == LEN_CODE_16) ? HDR_END_16 : HDR_END_64));
			end
			PH_KEY: begin
				fin_len = (code_q >= LEN_CODE_16) ? acc_q : {57'd0, code_q};
				fin_now = (hcnt_inc >= hsize);
			end
			default: begin
				fin_now = 1'b0;
			end
		endcase
		// header bytes seen once this byte is counted
		fin_hdr = (phase_q == PH_SECOND) ? 4'd2 : hcnt_inc;
		fin_sum = {1'b0, fin_len} + {61'd0, fin_hdr};
		too_big = fin_sum > {33'd0, max_q};
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_SECOND: begin
				if ((rx_byte[6:0] == LEN_CODE_16) || (rx_byte[6:0] == LEN_CODE_64))
					phase_d = PH_EXTLEN;
				else if (rx_byte[7])
					phase_d = PH_KEY;
				else
					phase_d = (fin_len != 64'd0) ? PH_PAYLOAD : PH_FIRST;
			end
			PH_EXTLEN: begin
				if (hcnt_inc == ((code_q == LEN_CODE_16) ? HDR_END_16 : HDR_END_64))
					phase_d = masked_q ? PH_KEY : ((fin_len != 64'd0) ? PH_PAYLOAD : PH_FIRST);
			end
			PH_KEY: begin
				if (fin_now)
					phase_d = (fin_len != 64'd0) ? PH_PAYLOAD : PH_FIRST;
			end
			PH_PAYLOAD: begin
				if (rem_dec == 64'd0)
					phase_d = PH_FIRST;
			end
			default: begin
				phase_d = PH_SECOND;
			end
		endcase
	end

	// datapath updates and transaction to the queue
	always_comb begin
		hcnt_d   = hcnt_q;
		first_d  = first_q;
		code_d   = code_q;
		acc_d    = acc_q;
		key_d    = key_q;
		rem_d    = rem_q;
		kidx_d   = kidx_q;
		disc_d   = disc_q;
		masked_d = masked_q;
		wr_en    = 1'b0;
		kbyte    = key_q[8 * (3 - kidx_q) +: 8];
		case (phase_q)
			PH_SECOND: begin
				masked_d = rx_byte[7];
				code_d   = rx_byte[6:0];
				hcnt_d   = 4'd2;
				acc_d    = 64'd0;
				key_d    = 32'd0;
			end
			PH_EXTLEN: begin
				acc_d  = {acc_q[55:0], rx_byte};
				hcnt_d = hcnt_inc;
			end
			PH_KEY: begin
				key_d  = {key_q[23:0], rx_byte};
				hcnt_d = hcnt_inc;
			end
			PH_PAYLOAD: begin
				rem_d = rem_dec;
				if (disc_q) begin
					if (rem_dec == 64'd0)
						disc_d = 1'b0;
				end else begin
					kidx_d = kidx_q + 2'd1;
					wr_en  = take;
				end
			end
			default: begin
				first_d = rx_byte;
				hcnt_d  = 4'd1;
				disc_d  = 1'b0;
			end
		endcase
		if (fin_now) begin
			acc_d  = fin_len;
			rem_d  = fin_len;
			kidx_d = 2'd0;
			disc_d = too_big && (fin_len != 64'd0);
			wr_en  = take;
		end

		wr_cmd.fin      = first_q[7];
		wr_cmd.rsv      = first_q[6:4];
		wr_cmd.opcode   = first_q[3:0];
		wr_cmd.masked   = masked_d;
		wr_cmd.length   = acc_d[62:0];
		wr_cmd.data     = 8'd0;
		wr_cmd.key_byte = 8'd0;
		if (fin_now) begin
			wr_cmd.kind = too_big ? KIND_ERROR : KIND_HEADER;
			wr_cmd.last = too_big || (fin_len == 64'd0);
		end else begin
			wr_cmd.kind     = KIND_PAYLOAD;
			wr_cmd.data     = rx_byte;
			wr_cmd.key_byte = kbyte;
			wr_cmd.last     = (rem_dec == 64'd0);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			hcnt_q   <= 4'd0;
			first_q  <= 8'd0;
			code_q   <= 7'd0;
			acc_q    <= 64'd0;
			key_q    <= 32'd0;
			rem_q    <= 64'd0;
			kidx_q   <= 2'd0;
			disc_q   <= 1'b0;
			masked_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			hcnt_q   <= hcnt_d;
			first_q  <= first_d;
			code_q   <= code_d;
			acc_q    <= acc_d;
			key_q    <= key_d;
			rem_q    <= rem_d;
			kidx_q   <= kidx_d;
			disc_q   <= disc_d;
			masked_q <= masked_d;
		end
	end

	// frame size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_q <= MAX_FRAME_RESET;
		else if (cfg_we)
			max_q <= cfg_wdata;
	end

	`WSFD_ASSERT_IMP(a_payload_rem, clk, arst_n, phase_q == PH_PAYLOAD, rem_q != 64'd0, "payload phase with nothing remaining")
	`WSFD_ASSERT_IMP(a_key_masked, clk, arst_n, phase_q == PH_KEY, masked_q, "key phase on unmasked frame")
	`WSFD_ASSERT_NEXT(a_discard_quiet, clk, arst_n, take && (phase_q == PH_PAYLOAD) && disc_q, disc_q || (phase_q == PH_FIRST), "discard ended before frame end")

endmodule

### sv/wsfd_queue.sv
// short queue between parser and output stage, registered read port
// depends on wsfd_pkg and websocket_frame_deframer_assert.svh
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"

module wsfd_queue
	import wsfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic full,
	output logic nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	cmd_t             rd_data_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_cmd   = rd_data_q;

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_cmd;
		if (rd_en)
			rd_data_q <= mem_q[rd_ptr_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	`WSFD_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`WSFD_ASSERT_IMP(a_no_underrun, clk, arst_n, rd_en, nonempty, "queue read while empty")
	`WSFD_ASSERT_IMP(a_no_overrun, clk, arst_n, wr_en, !full, "queue write while full")

endmodule

### sv/wsfd_emit.sv
// back end: output register control and payload unmasking
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_emit
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  cmd_t        q_cmd,
	output logic        q_rd_en,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  kind,
	output logic        fin,
	output logic [2:0]  reserved_bits,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [62:0] decoded_length,
	output logic [7:0]  payload_byte,
	output logic        last
);

	logic out_valid_q;

	// refill the output register when it is free or being taken
	assign q_rd_en = q_nonempty && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_rd_en)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	// result fields, payload unmasked with its key byte
	assign empty          = !out_valid_q;
	assign kind           = q_cmd.kind;
	assign fin            = q_cmd.fin;
	assign reserved_bits  = q_cmd.rsv;
	assign opcode         = q_cmd.opcode;
	assign masked         = q_cmd.masked;
	assign decoded_length = q_cmd.length;
	assign payload_byte   = q_cmd.data ^ q_cmd.key_byte;
	assign last           = q_cmd.last;

endmodule
